FILE: src/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

	// Width and reset value of the capacity limit register.
	localparam int LIMIT_W = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// Operation codes carried in the input tuser bit.
	localparam logic FUNC_PUT = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	// Control broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic lookup;     // compare the incoming key and keep the match flag
		logic shift_all;  // put miss: every cell takes its neighbor's entry
		logic shift_hit;  // hit: cells up to the hit cell take their neighbor's entry
	} cell_ctrl_t;

endpackage

FILE: src/lkvc_cell.sv
// One cache entry of the recency chain: key, value, valid flag and match flag.
module lkvc_cell #(
	parameter int KEY_WIDTH   = 16,
	parameter int VALUE_WIDTH = 16,
	parameter int INDEX       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkvc_pkg::cell_ctrl_t          ctrl,
	input  logic [lkvc_pkg::LIMIT_W-1:0]  limit,
	input  logic [KEY_WIDTH-1:0]          lookup_key,
	input  logic                          prev_valid,
	input  logic [KEY_WIDTH-1:0]          prev_key,
	input  logic [VALUE_WIDTH-1:0]        prev_value,
	input  logic                          prev_seen,
	output logic                          valid,
	output logic [KEY_WIDTH-1:0]          key,
	output logic [VALUE_WIDTH-1:0]        value,
	output logic                          match,
	output logic                          seen,
	output logic [VALUE_WIDTH-1:0]        hit_value
);
	import lkvc_pkg::*;

	logic                   valid_q;
	logic                   match_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   keep;
	logic                   take;

	// A cell stays in use after a put miss only while it lies below the limit.
	// The first cell is always kept, so a limit of zero acts as one.
	assign keep = (INDEX == 0) || (32'(limit) > INDEX);

	// The hit ripples down the chain; the cells from the head down to the hit cell move.
	assign seen = prev_seen | match_q;
	assign take = ctrl.shift_all | (ctrl.shift_hit & ~prev_seen);

	// Valid and match flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= prev_valid & (~ctrl.shift_all | keep);
			end
			if (ctrl.lookup) begin
				match_q <= valid_q && (key_q == lookup_key);
			end
		end
	end

	// Entry payload moves one cell further from the most recent end.
	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign valid     = valid_q;
	assign key       = key_q;
	assign value     = value_q;
	assign match     = match_q;
	assign hit_value = value_q & {VALUE_WIDTH{match_q}};

endmodule

FILE: src/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache built as a chain of cells.
//
//   port group  | direction | contents
//   ------------+-----------+-----------------------------------------------
//   s_*         | in        | tuser: func; tdata: key, value
//   m_*         | out       | tuser: hit; tdata: read_value
//   cfg_*       | in        | capacity limit write, no read-back
//
// At the accepting edge every cell compares the key; in the update state the chain
// shifts and a get result is loaded into the output register. A get waits in the
// update state while the output register is full and is not being read.
// The cell nearest the input holds the most recent entry; the hit search ripples
// through all CAPACITY cells in the update state, which sets the clock limit.
// Reset empties the cache and sets the capacity limit to 16; no clearing pass.
module lru_key_value_cache #(
	parameter int CAPACITY    = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int VALUE_WIDTH = 16,
	localparam int S_TDATA_W  = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
	localparam int M_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          s_tuser,   // func
	input  logic [S_TDATA_W-1:0]          s_tdata,   // key, value, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          m_tuser,   // hit
	output logic [M_TDATA_W-1:0]          m_tdata,   // read_value, zero pad
	input  logic                          cfg_we,
	input  logic [lkvc_pkg::LIMIT_W-1:0]  cfg_wdata
);
	import lkvc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} state_t;

	state_t                  state_q;
	logic [LIMIT_W-1:0]      limit_q;
	logic                    func_s1;
	logic [KEY_WIDTH-1:0]    key_s1;
	logic [VALUE_WIDTH-1:0]  value_s1;
	logic                    m_valid_q;
	logic                    out_hit_q;
	logic [VALUE_WIDTH-1:0]  out_value_q;

	logic                    accept;
	logic                    out_free;
	logic                    go;
	logic                    any_hit;
	logic [VALUE_WIDTH-1:0]  hit_value;
	cell_ctrl_t              ctrl;

	logic [CAPACITY-1:0]     valid_vec;
	logic [CAPACITY-1:0]     match_vec;
	logic [CAPACITY-1:0]     seen_vec;
	logic [KEY_WIDTH-1:0]    key_vec   [CAPACITY];
	logic [VALUE_WIDTH-1:0]  value_vec [CAPACITY];
	logic [VALUE_WIDTH-1:0]  hv_vec    [CAPACITY];

	// Handshake and sequencing.
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = ~m_valid_q | m_tready;
	assign go       = (state_q == ST_UPDATE) && ((func_s1 == FUNC_PUT) || out_free);
	assign any_hit  = seen_vec[CAPACITY-1];

	assign ctrl.lookup    = accept;
	assign ctrl.shift_all = go && (func_s1 == FUNC_PUT) && !any_hit;
	assign ctrl.shift_hit = go && any_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capacity limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Item held for the update state.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= s_tuser;
			key_s1   <= s_tdata[KEY_WIDTH-1:0];
			value_s1 <= s_tdata[KEY_WIDTH +: VALUE_WIDTH];
		end
	end

	// Value of the matching cell; at most one cell matches, so an OR selects it.
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | hv_vec[i];
		end
	end

	// Chain of cells, most recent entry first.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                   pv;
		logic [KEY_WIDTH-1:0]   pk;
		logic [VALUE_WIDTH-1:0] pval;
		logic                   ps;

		if (i == 0) begin : g_head
			// The head takes the item itself: a put brings its own value, a get the value of the hit cell.
			assign pv   = 1'b1;
			assign pk   = key_s1;
			assign pval = (func_s1 == FUNC_PUT) ? value_s1 : hit_value;
			assign ps   = 1'b0;
		end else begin : g_link
			assign pv   = valid_vec[i-1];
			assign pk   = key_vec[i-1];
			assign pval = value_vec[i-1];
			assign ps   = seen_vec[i-1];
		end

		lkvc_cell #(
			.KEY_WIDTH   (KEY_WIDTH),
			.VALUE_WIDTH (VALUE_WIDTH),
			.INDEX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.limit      (limit_q),
			.lookup_key (s_tdata[KEY_WIDTH-1:0]),
			.prev_valid (pv),
			.prev_key   (pk),
			.prev_value (pval),
			.prev_seen  (ps),
			.valid      (valid_vec[i]),
			.key        (key_vec[i]),
			.value      (value_vec[i]),
			.match      (match_vec[i]),
			.seen       (seen_vec[i]),
			.hit_value  (hv_vec[i])
		);
	end

	// Output register for get results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go && (func_s1 == FUNC_GET)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && (func_s1 == FUNC_GET)) begin
			out_hit_q   <= any_hit;
			out_value_q <= hit_value;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = M_TDATA_W'(out_value_q);

`ifndef SYNTH
	// A key is held by one cell at most.
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matches the key");

	// Occupied cells form an unbroken run from the most recent end.
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("gap in the occupied cells");

	// A miss result carries a zero value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss result with nonzero value");

	// No item is taken while the previous one is being applied.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted during update");
`endif

endmodule

FILE: tb/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache: directed and random puts and gets.
`timescale 1ns / 100ps

// Result of one get, as the cache is expected to return it.
typedef struct {
	logic        hit;
	logic [15:0] read_value;
} read_result_t;

// One cached key and its value.
typedef struct {
	logic [15:0] key;
	logic [15:0] value;
} cache_entry_t;

// Tracks the cache contents in recency order and checks every get result.
class lru_cache_tracker;
	cache_entry_t entries[$];        // most recent entry first
	read_result_t pending_reads[$];  // get results not yet returned
	int unsigned  depth;
	int unsigned  limit;
	int unsigned  errors;

	function new(int unsigned cache_depth);
		depth = cache_depth;
		errors = 0;
		set_limit(lkvc_pkg::LIMIT_RESET);
	endfunction

	// A limit of zero acts as one, and a limit above the depth acts as the depth.
	function void set_limit(logic [lkvc_pkg::LIMIT_W-1:0] raw);
		if (raw == 0) begin
			limit = 1;
		end else if (raw > depth) begin
			limit = depth;
		end else begin
			limit = raw;
		end
	endfunction

	function int lookup(logic [15:0] key);
		foreach (entries[i]) begin
			if (entries[i].key == key) return i;
		end
		return -1;
	endfunction

	// Applies one accepted input item and queues the result a get should give.
	function void note_access(logic func, logic [15:0] key, logic [15:0] value);
		int           slot;
		cache_entry_t e;
		read_result_t r;
		slot = lookup(key);
		if (func == lkvc_pkg::FUNC_PUT) begin
			// A hit drops the old copy; a miss evicts from the old end until there is room.
			if (slot >= 0) begin
				entries.delete(slot);
			end else begin
				while (entries.size() >= limit) entries.delete(entries.size() - 1);
			end
			e.key = key;
			e.value = value;
			entries.push_front(e);
		end else begin
			r.hit = (slot >= 0);
			r.read_value = '0;
			if (slot >= 0) begin
				e = entries[slot];
				r.read_value = e.value;
				entries.delete(slot);
				entries.push_front(e);
			end
			pending_reads.push_back(r);
		end
	endfunction

	function void report(string what);
		errors++;
		if (errors <= 10) $display("%0t: %s", $realtime, what);
	endfunction

	// Compares one returned result with the oldest outstanding get.
	function void check_read(logic hit, logic [15:0] read_value);
		read_result_t r;
		if (pending_reads.size() == 0) begin
			report($sformatf("unexpected result: hit %0b value %h", hit, read_value));
			return;
		end
		r = pending_reads.pop_front();
		if (hit !== r.hit) begin
			report($sformatf("hit flag: expected %0b, got %0b", r.hit, hit));
		end
		if (read_value !== r.read_value) begin
			report($sformatf("read value: expected %h, got %h", r.read_value, read_value));
		end
	endfunction
endclass

module tb_lru_key_value_cache;
	import lkvc_pkg::*;

	localparam int CACHE_DEPTH = 16;
	localparam int ITEMS_PER_PHASE = 62;
	localparam int NUM_PHASES = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic                s_tuser;     // func
	logic [31:0]         s_tdata;     // key, value
	logic                m_tvalid;
	logic                m_tready;
	logic                m_tuser;     // hit
	logic [15:0]         m_tdata;     // read_value
	logic                cfg_we;
	logic [LIMIT_W-1:0]  cfg_wdata;

	lru_cache_tracker tracker;
	int unsigned      send_gap_pct;
	int unsigned      recv_stall_pct;
	int unsigned      quiet_cycles;

	lru_key_value_cache #(
		.CAPACITY(CACHE_DEPTH),
		.KEY_WIDTH(16),
		.VALUE_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random with the current stall rate.
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Checks every result transfer and ends the run if transfers stop.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_read(m_tuser, m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("lru_key_value_cache: mismatch");
			$finish;
		end
	end

	// Offers one item, called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(logic func, logic [15:0] key, logic [15:0] value);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = func;
		s_tdata = {value, key};
		do @(posedge clk); while (!s_tready);
		tracker.note_access(func, key, value);
		@(negedge clk);
	endtask

	// Lets the cache go idle, then writes the capacity limit.
	task automatic write_limit(logic [LIMIT_W-1:0] raw);
		s_tvalid = 1'b0;
		while (tracker.pending_reads.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = raw;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_limit(raw);
	endtask

	// One random phase: keys mostly come from a small pool so that hits and evictions are common.
	task automatic run_phase(logic [LIMIT_W-1:0] raw);
		logic [15:0] pool[32];
		int          pool_size;
		logic [15:0] key;
		write_limit(raw);
		pool_size = tracker.limit + tracker.limit / 2 + 2;
		for (int i = 0; i < pool_size; i++) pool[i] = 16'($urandom);
		pool[0] = 16'h0000;
		pool[1] = 16'hFFFF;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			if ($urandom_range(99) < 85) begin
				key = pool[$urandom_range(pool_size - 1)];
			end else begin
				key = 16'($urandom);
			end
			send_item(1'($urandom_range(1)), key, 16'($urandom));
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] phase_limits[NUM_PHASES];
		tracker = new(CACHE_DEPTH);
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = FUNC_PUT;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet_cycles = 0;
		send_gap_pct = 10;
		recv_stall_pct = 60;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset limit: empty miss, extreme keys and values, overwrite.
		send_item(FUNC_GET, 16'h0000, 16'hFFFF);
		send_item(FUNC_PUT, 16'h0000, 16'hFFFF);
		send_item(FUNC_PUT, 16'hFFFF, 16'h0000);
		send_item(FUNC_GET, 16'h0000, 16'h0000);
		send_item(FUNC_GET, 16'hFFFF, 16'hFFFF);
		send_item(FUNC_PUT, 16'h0000, 16'h1234);
		send_item(FUNC_GET, 16'h0000, 16'h0000);
		send_item(FUNC_GET, 16'h5555, 16'h0000);
		// Overfill by one so the least recent key is evicted.
		for (int i = 0; i < 15; i++) begin
			send_item(FUNC_PUT, 16'(16'h0100 + i), 16'(16'hA500 + i));
		end
		send_item(FUNC_GET, 16'hFFFF, 16'h0000);
		send_item(FUNC_GET, 16'h0100, 16'h0000);
		// Lower the limit below the fill: the next missing put evicts down to make room.
		write_limit(5'd2);
		send_item(FUNC_PUT, 16'hAAAA, 16'h5A5A);
		send_item(FUNC_GET, 16'h0100, 16'h0000);

		// Random part across several limits, the extremes among them.
		phase_limits = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd5, 5'd2, 5'd0};
		phase_limits[NUM_PHASES - 1] = LIMIT_W'($urandom_range(31));
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 3) begin
				send_gap_pct = 10;
				recv_stall_pct = 60;
			end else if (p < 6) begin
				send_gap_pct = 60;
				recv_stall_pct = 10;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			run_phase(phase_limits[p]);
		end

		// Drain outstanding gets and let the last put settle.
		s_tvalid = 1'b0;
		while (tracker.pending_reads.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.errors == 0) begin
			$display("lru_key_value_cache: match");
		end else begin
			$display("lru_key_value_cache: mismatch");
		end
		$finish;
	end

endmodule
